[rtl/assert_macros.svh]
// assertion macros used by the decoder top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property checked on every rising clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// antecedent implies consequent on the next clock edge
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst, expr)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

[rtl/sfcd_pkg.sv]
// types, constants and the crc function of the sensor frame decoder
package sfcd_pkg;

   localparam logic [7:0]  CRC_INIT    = 8'hFF;
   localparam logic [7:0]  CRC_POLY    = 8'h31;
   localparam logic [3:0]  LAST_POS    = 4'd8;
   localparam logic [14:0] TEMP_SCALE  = 15'd17500;
   localparam logic [14:0] TEMP_OFFSET = 15'd4500;
   localparam logic [13:0] HUMID_SCALE = 14'd10000;

   // one completed frame, handed from the byte tracker to the converter
   typedef struct packed {
      logic        fail;
      logic [15:0] co2;
      logic [15:0] temp;
      logic [15:0] humid;
   } frame_type;

   // crc-8, msb first, one byte folded in
   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] v;
      v = crc ^ data;
      for (int b = 0; b < 8; b++) begin
         v = v[7] ? ((v << 1) ^ CRC_POLY) : (v << 1);
      end
      return v;
   endfunction

endpackage

[rtl/sensor_frame_crc_decoder.sv]
// sensor frame crc decoder top level: byte tracker, converter and result register
// one byte per cycle while req_ready; a frame closed by its ninth byte goes to the
// frame record register, then result register; ready stays high while rsp flows
// synchronous active-high reset clears position, crc, error flag and valid flags
`include "assert_macros.svh"

module sensor_frame_crc_decoder (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_rx_byte,
   input  logic               req_frame_start,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_status,
   output logic [15:0]        rsp_co2_ppm,
   output logic [15:0]        rsp_temp_raw_word,
   output logic [15:0]        rsp_humid_raw_word,
   output logic signed [14:0] rsp_temperature_centi,
   output logic [13:0]        rsp_humidity_centi
);
   import sfcd_pkg::*;

   logic               byte_take;
   logic               frame_valid;
   logic               frame_advance;
   frame_type          frame_rec;

   logic               conv_status;
   logic [15:0]        conv_co2;
   logic [15:0]        conv_temp_raw;
   logic [15:0]        conv_humid_raw;
   logic signed [14:0] conv_temp_centi;
   logic [13:0]        conv_humid_centi;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               status_ff;
   logic [15:0]        co2_ff;
   logic [15:0]        temp_raw_ff;
   logic [15:0]        humid_raw_ff;
   logic signed [14:0] temp_centi_ff;
   logic [13:0]        humid_centi_ff;
   logic               rsp_fields_zero;

   // result register frees up when empty or taken this cycle
   assign frame_advance = !rsp_valid_ff || rsp_ready;
   assign req_ready     = !frame_valid || frame_advance;
   assign byte_take     = req_valid && req_ready;
   assign rsp_valid_in  = frame_advance ? frame_valid : rsp_valid_ff;

   sfcd_frame u_frame (
      .clock         (clock),
      .reset         (reset),
      .byte_take     (byte_take),
      .rx_byte       (req_rx_byte),
      .frame_start   (req_frame_start),
      .frame_advance (frame_advance),
      .frame_valid   (frame_valid),
      .frame_rec     (frame_rec)
   );

   sfcd_conv u_conv (
      .frame_rec         (frame_rec),
      .status            (conv_status),
      .co2_ppm           (conv_co2),
      .temp_raw_word     (conv_temp_raw),
      .humid_raw_word    (conv_humid_raw),
      .temperature_centi (conv_temp_centi),
      .humidity_centi    (conv_humid_centi)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (frame_advance && frame_valid) begin
         status_ff      <= conv_status;
         co2_ff         <= conv_co2;
         temp_raw_ff    <= conv_temp_raw;
         humid_raw_ff   <= conv_humid_raw;
         temp_centi_ff  <= conv_temp_centi;
         humid_centi_ff <= conv_humid_centi;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = status_ff;
   assign rsp_co2_ppm           = co2_ff;
   assign rsp_temp_raw_word     = temp_raw_ff;
   assign rsp_humid_raw_word    = humid_raw_ff;
   assign rsp_temperature_centi = temp_centi_ff;
   assign rsp_humidity_centi    = humid_centi_ff;

   assign rsp_fields_zero = (co2_ff == 16'd0) && (temp_raw_ff == 16'd0) &&
                            (humid_raw_ff == 16'd0) && (humid_centi_ff == 14'd0);

   `ASSERT_ALWAYS(a_ready_when_empty, clock, reset, rsp_valid_ff || req_ready)
   `ASSERT_ALWAYS(a_error_zeroes, clock, reset, !(rsp_valid_ff && status_ff) || rsp_fields_zero)
   `ASSERT_ALWAYS(a_humid_range, clock, reset, !rsp_valid_ff || humid_centi_ff < 14'd10000)
   `ASSERT_NEXT(a_frame_moves, clock, reset, frame_valid && !rsp_valid_ff, rsp_valid_ff)

endmodule

[rtl/sfcd_frame.sv]
// byte position tracker, word assembly and crc check, with the frame record register
module sfcd_frame (
   input  logic                clock,
   input  logic                reset,
   input  logic                byte_take,
   input  logic [7:0]          rx_byte,
   input  logic                frame_start,
   input  logic                frame_advance,
   output logic                frame_valid,
   output sfcd_pkg::frame_type frame_rec
);
   import sfcd_pkg::*;

   typedef enum logic [1:0] {
      PHASE_HIGH,
      PHASE_LOW,
      PHASE_CHECK
   } phase_type;

   localparam logic [3:0] POS_CO2_LOW  = 4'd1;
   localparam logic [3:0] POS_TEMP_LOW = 4'd4;

   logic [3:0]  pos_ff, pos_in;
   logic [7:0]  crc_ff, crc_in;
   logic [7:0]  high_ff, high_in;
   logic [15:0] co2_ff, co2_in;
   logic [15:0] temp_ff, temp_in;
   logic [15:0] humid_ff, humid_in;
   logic        fail_ff, fail_in;
   logic        frame_valid_ff, frame_valid_in;
   frame_type   frame_ff, frame_in;

   logic        restart;
   logic [3:0]  pos;
   logic        fail_now;
   logic        last;
   phase_type   phase;

   always_comb begin
      restart = frame_start || (pos_ff > LAST_POS);
      pos     = restart ? 4'd0 : pos_ff;
      last    = (pos == LAST_POS);
      unique case (pos) inside
         4'd0, 4'd3, 4'd6: phase = PHASE_HIGH;
         4'd1, 4'd4, 4'd7: phase = PHASE_LOW;
         default:          phase = PHASE_CHECK;
      endcase
   end

   always_comb begin
      crc_in   = crc_ff;
      high_in  = high_ff;
      co2_in   = co2_ff;
      temp_in  = temp_ff;
      humid_in = humid_ff;
      fail_now = restart ? 1'b0 : fail_ff;
      unique case (phase)
         PHASE_HIGH: begin
            crc_in  = crc8_update(CRC_INIT, rx_byte);
            high_in = rx_byte;
         end
         PHASE_LOW: begin
            crc_in = crc8_update(crc_ff, rx_byte);
            if (pos == POS_CO2_LOW) begin
               co2_in = {high_ff, rx_byte};
            end else if (pos == POS_TEMP_LOW) begin
               temp_in = {high_ff, rx_byte};
            end else begin
               humid_in = {high_ff, rx_byte};
            end
         end
         default: begin
            fail_now = fail_now | (crc_ff != rx_byte);
         end
      endcase
      pos_in  = last ? 4'd0 : pos + 4'd1;
      fail_in = last ? 1'b0 : fail_now;
   end

   // the ninth byte closes the frame; the humidity word is already held
   always_comb begin
      frame_in.fail  = fail_now;
      frame_in.co2   = co2_ff;
      frame_in.temp  = temp_ff;
      frame_in.humid = humid_ff;
      if (byte_take && last) begin
         frame_valid_in = 1'b1;
      end else if (frame_advance) begin
         frame_valid_in = 1'b0;
      end else begin
         frame_valid_in = frame_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff         <= 4'd0;
         crc_ff         <= CRC_INIT;
         fail_ff        <= 1'b0;
         frame_valid_ff <= 1'b0;
      end else begin
         frame_valid_ff <= frame_valid_in;
         if (byte_take) begin
            pos_ff  <= pos_in;
            crc_ff  <= crc_in;
            fail_ff <= fail_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (byte_take) begin
         high_ff  <= high_in;
         co2_ff   <= co2_in;
         temp_ff  <= temp_in;
         humid_ff <= humid_in;
         if (last) begin
            frame_ff <= frame_in;
         end
      end
   end

   assign frame_valid = frame_valid_ff;
   assign frame_rec   = frame_ff;

endmodule

[rtl/sfcd_conv.sv]
// temp and humid words scaled to hundredths; frames with a crc error are zeroed
module sfcd_conv (
   input  sfcd_pkg::frame_type frame_rec,
   output logic                status,
   output logic [15:0]         co2_ppm,
   output logic [15:0]         temp_raw_word,
   output logic [15:0]         humid_raw_word,
   output logic signed [14:0]  temperature_centi,
   output logic [13:0]         humidity_centi
);
   import sfcd_pkg::*;

   logic [30:0] temp_prod;
   logic [29:0] humid_prod;
   logic [14:0] temp_diff;

   always_comb begin
      temp_prod  = {15'd0, frame_rec.temp} * {16'd0, TEMP_SCALE};
      humid_prod = {14'd0, frame_rec.humid} * {16'd0, HUMID_SCALE};
      // offset fits the 15-bit two's complement range for every raw word
      temp_diff  = temp_prod[30:16] - TEMP_OFFSET;
      status     = frame_rec.fail;
      if (frame_rec.fail) begin
         co2_ppm           = 16'd0;
         temp_raw_word     = 16'd0;
         humid_raw_word    = 16'd0;
         temperature_centi = 15'sd0;
         humidity_centi    = 14'd0;
      end else begin
         co2_ppm           = frame_rec.co2;
         temp_raw_word     = frame_rec.temp;
         humid_raw_word    = frame_rec.humid;
         temperature_centi = signed'(temp_diff);
         humidity_centi    = humid_prod[29:16];
      end
   end

endmodule

[verif/tb.sv]
// testbench for the sensor frame crc decoder: frame stimulus, prediction and result checks
`timescale 1ns / 1ps

module tb;
   import sfcd_pkg::CRC_INIT;
   import sfcd_pkg::CRC_POLY;
   import sfcd_pkg::LAST_POS;
   import sfcd_pkg::TEMP_SCALE;
   import sfcd_pkg::TEMP_OFFSET;
   import sfcd_pkg::HUMID_SCALE;

   localparam int STUCK_LIMIT    = 2000;
   localparam int RANDOM_UPTO    = 680;
   localparam int REPORT_LIMIT   = 10;
   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_CRC   = 1'b1;

   typedef struct {
      logic        status;
      logic [15:0] co2;
      logic [15:0] temp;
      logic [15:0] humid;
      logic [14:0] temp_c;
      logic [13:0] humid_c;
   } reading_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [7:0]         req_rx_byte = 8'h00;
   logic               req_frame_start = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_status;
   logic [15:0]        rsp_co2_ppm;
   logic [15:0]        rsp_temp_raw_word;
   logic [15:0]        rsp_humid_raw_word;
   logic signed [14:0] rsp_temperature_centi;
   logic [13:0]        rsp_humidity_centi;

   // predictor state, mirrors the frame tracker
   logic [3:0]  frame_pos = 4'd0;
   logic [7:0]  word_crc = CRC_INIT;
   logic [7:0]  high_byte = 8'h00;
   logic [15:0] co2_word = 16'h0000;
   logic [15:0] temp_word = 16'h0000;
   logic [15:0] humid_word = 16'h0000;
   logic        crc_bad = 1'b0;

   reading_type pending_readings[$];
   int       mismatches = 0;
   int       bytes_sent = 0;
   bit       req_gaps_on = 1'b1;
   bit       rsp_stalls_on = 1'b1;
   int       stall_left = 0;

   sensor_frame_crc_decoder dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_rx_byte           (req_rx_byte),
      .req_frame_start       (req_frame_start),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_status            (rsp_status),
      .rsp_co2_ppm           (rsp_co2_ppm),
      .rsp_temp_raw_word     (rsp_temp_raw_word),
      .rsp_humid_raw_word    (rsp_humid_raw_word),
      .rsp_temperature_centi (rsp_temperature_centi),
      .rsp_humidity_centi    (rsp_humidity_centi)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] r;
      r = crc ^ data;
      repeat (8) r = r[7] ? ({r[6:0], 1'b0} ^ CRC_POLY) : {r[6:0], 1'b0};
      return r;
   endfunction

   // fold one accepted byte into the predictor, queue a reading on the last byte
   task automatic predict_byte(input logic [7:0] data, input logic start);
      logic [3:0]  pos;
      logic [31:0] t_prod;
      logic [31:0] h_prod;
      reading_type r;
      pos = frame_pos;
      if (start || pos > LAST_POS) begin
         pos = 4'd0;
         crc_bad = 1'b0;
      end
      case (pos % 3)
         0: begin
            word_crc = crc8_byte(CRC_INIT, data);
            high_byte = data;
         end
         1: begin
            word_crc = crc8_byte(word_crc, data);
            if (pos == 4'd1) co2_word = {high_byte, data};
            else if (pos == 4'd4) temp_word = {high_byte, data};
            else humid_word = {high_byte, data};
         end
         default: begin
            if (word_crc != data) crc_bad = 1'b1;
         end
      endcase
      if (pos == LAST_POS) begin
         frame_pos = 4'd0;
         if (crc_bad) begin
            r = '{STATUS_CRC, 16'h0, 16'h0, 16'h0, 15'h0, 14'h0};
         end else begin
            t_prod = 32'(TEMP_SCALE) * 32'(temp_word);
            h_prod = 32'(HUMID_SCALE) * 32'(humid_word);
            r.status = STATUS_OK;
            r.co2 = co2_word;
            r.temp = temp_word;
            r.humid = humid_word;
            r.temp_c = t_prod[30:16] - TEMP_OFFSET;
            r.humid_c = h_prod[29:16];
         end
         pending_readings.push_back(r);
         crc_bad = 1'b0;
      end else begin
         frame_pos = pos + 4'd1;
      end
   endtask

   // valid stays high after acceptance until the next byte or an explicit drop
   task automatic send_byte(input logic [7:0] data, input logic start);
      int gap;
      if (req_gaps_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 14);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= data;
      req_frame_start <= start;
      do @(posedge clock); while (!req_ready);
      predict_byte(data, start);
      bytes_sent++;
   endtask

   // bad_words marks which words get a corrupted crc byte; len cuts the frame short
   task automatic send_frame(input logic [15:0] co2, input logic [15:0] temp,
                             input logic [15:0] humid, input logic start,
                             input logic [2:0] bad_words, input int len);
      logic [15:0] words[3];
      logic [7:0]  fb[9];
      logic [7:0]  c;
      words = '{co2, temp, humid};
      for (int w = 0; w < 3; w++) begin
         c = crc8_byte(crc8_byte(CRC_INIT, words[w][15:8]), words[w][7:0]);
         if (bad_words[w]) c = c ^ 8'($urandom_range(1, 255));
         fb[3*w]   = words[w][15:8];
         fb[3*w+1] = words[w][7:0];
         fb[3*w+2] = c;
      end
      for (int i = 0; i < len; i++) send_byte(fb[i], (i == 0) ? start : 1'b0);
   endtask

   function automatic logic [15:0] rand_word();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [2:0] rand_bad_words();
      return ($urandom_range(0, 7) == 0) ? 3'($urandom_range(1, 7)) : 3'b000;
   endfunction

   task automatic wait_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_readings.size() != 0);
   endtask

   task automatic test_extremes();
      send_frame(16'hFFFF, 16'h0000, 16'hFFFF, 1'b1, 3'b000, 9);
   endtask

   // bad crc in a partial frame, then a start flag drops it and clears the error
   task automatic test_restart();
      send_frame(16'h1234, 16'h0000, 16'h0000, 1'b1, 3'b001, 3);
      send_frame(16'h0000, 16'hFFFF, 16'h0000, 1'b1, 3'b000, 9);
   endtask

   // no start flag: position wraps from the last frame
   task automatic test_crc_error();
      send_frame(16'h0190, 16'h6666, 16'h8000, 1'b0, 3'b100, 9);
   endtask

   task automatic test_random_traffic();
      int kind;
      int n;
      bit force_start;
      force_start = 1'b0;
      while (bytes_sent < RANDOM_UPTO) begin
         kind = $urandom_range(0, 19);
         if (kind < 15) begin
            send_frame(rand_word(), rand_word(), rand_word(),
                       force_start | 1'($urandom_range(0, 1)), rand_bad_words(), 9);
            force_start = 1'b0;
         end else if (kind < 18) begin
            send_frame(rand_word(), rand_word(), rand_word(), 1'($urandom_range(0, 1)),
                       rand_bad_words(), $urandom_range(1, 8));
            force_start = ($urandom_range(0, 3) != 0);
         end else begin
            n = $urandom_range(1, 4);
            repeat (n) send_byte(8'($urandom), 1'($urandom_range(0, 1)));
            force_start = ($urandom_range(0, 3) != 0);
         end
      end
   endtask

   task automatic test_drain_pause();
      send_frame(rand_word(), rand_word(), rand_word(), 1'b1, 3'b000, 9);
      wait_until_drained();
      send_frame(rand_word(), rand_word(), rand_word(), 1'b0, rand_bad_words(), 9);
   endtask

   task automatic test_steady_stream();
      req_gaps_on = 1'b0;
      rsp_stalls_on = 1'b0;
      repeat (8) begin
         send_frame(rand_word(), rand_word(), rand_word(), 1'($urandom_range(0, 1)),
                    rand_bad_words(), 9);
      end
   endtask

   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (rsp_stalls_on && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 13);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_readings
      reading_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_readings.size() == 0) begin
            if (mismatches < REPORT_LIMIT) begin
               $display("%0t: unexpected reading status=%b co2=%h", $time, rsp_status,
                        rsp_co2_ppm);
            end
            mismatches++;
         end else begin
            want = pending_readings.pop_front();
            if (rsp_status !== want.status || rsp_co2_ppm !== want.co2 ||
                rsp_temp_raw_word !== want.temp || rsp_humid_raw_word !== want.humid ||
                rsp_temperature_centi !== want.temp_c ||
                rsp_humidity_centi !== want.humid_c) begin
               if (mismatches < REPORT_LIMIT) begin
                  $display("%0t: expected st=%b co2=%h t=%h h=%h tc=%0d hc=%0d", $time,
                           want.status, want.co2, want.temp, want.humid,
                           $signed(want.temp_c), want.humid_c);
                  $display("%0t:   actual st=%b co2=%h t=%h h=%h tc=%0d hc=%0d", $time,
                           rsp_status, rsp_co2_ppm, rsp_temp_raw_word, rsp_humid_raw_word,
                           rsp_temperature_centi, rsp_humidity_centi);
               end
               mismatches++;
            end
         end
      end
   end

   // ends the run if no transaction moves for too long
   initial begin : watchdog
      int stuck;
      stuck = 0;
      while (stuck < STUCK_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stuck = 0;
         else stuck++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_restart();
      test_crc_error();
      test_random_traffic();
      test_drain_pause();
      test_steady_stream();
      req_valid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0 && pending_readings.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+rtl
rtl/sfcd_pkg.sv
rtl/sfcd_frame.sv
rtl/sfcd_conv.sv
rtl/sensor_frame_crc_decoder.sv
verif/tb.sv
